>>> rtl/sclm_pkg.sv
// Shared types and constants of the scalar-to-color lookup mapper.
`default_nettype none

package sclm_pkg;

  typedef enum logic [2:0] {
    REG_RANGE_LOW     = 3'd0,
    REG_RANGE_HIGH    = 3'd1,
    REG_INDEX_SCALE   = 3'd2,
    REG_ALPHA_FACTOR  = 3'd3,
    REG_OUTPUT_FORMAT = 3'd4,
    REG_COLOR_COUNT   = 3'd5
  } reg_addr_e;

  typedef enum logic [1:0] {
    FMT_RGBA      = 2'd0,
    FMT_RGB       = 2'd1,
    FMT_LUM_ALPHA = 2'd2,
    FMT_LUM       = 2'd3
  } format_e;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_MAP   = 1'b1
  } command_e;

  typedef struct packed {
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
    logic [31:0]        index_scale;
    logic [8:0]         alpha_factor;
    format_e            output_format;
    logic [8:0]         color_count;
  } cfg_t;

  typedef struct packed {
    command_e    command;
    logic        is_nan;
    logic        last;
    logic [8:0]  entry;
    logic [31:0] color;
  } item_t;

  typedef struct packed {
    command_e    command;
    logic        wr_ok;
    logic        last;
    logic [31:0] color;
  } lookup_t;

  typedef struct packed {
    logic       last;
    logic [2:0] count;
    logic [7:0] byte3;
    logic [7:0] byte2;
    logic [7:0] byte1;
    logic [7:0] byte0;
  } pixel_t;

  localparam logic signed [31:0] RST_RANGE_LOW    = 32'sd0;
  localparam logic signed [31:0] RST_RANGE_HIGH   = 32'sd65536;
  localparam logic [31:0]        RST_INDEX_SCALE  = 32'd65536;
  localparam logic [8:0]         RST_ALPHA_FACTOR = 9'd256;
  localparam logic [8:0]         RST_COLOR_COUNT  = 9'd256;

  localparam logic [8:0]  ALPHA_UNITY = 9'd256;
  localparam logic [15:0] LUM_R_COEF  = 16'd77;
  localparam logic [15:0] LUM_G_COEF  = 16'd151;
  localparam logic [15:0] LUM_B_COEF  = 16'd28;
  localparam logic [15:0] ROUND_HALF  = 16'd128;

  localparam logic [2:0] COUNT_RGBA      = 3'd4;
  localparam logic [2:0] COUNT_RGB       = 3'd3;
  localparam logic [2:0] COUNT_LUM_ALPHA = 3'd2;
  localparam logic [2:0] COUNT_LUM       = 3'd1;

endpackage

`default_nettype wire

>>> rtl/scalar_to_color_lut_mapper.sv
// Top level of the scalar-to-color lookup mapper.
// With the output free, takes one transaction per clock and sustains one
// pixel per clock. An accepted map command passes through input capture,
// range check and offset, the 32x32 index-scale multiply, slot selection
// and clamp, the registered table read, and the formatting stage that
// holds the output. Write commands load one table entry (TABLE_DEPTH
// colors plus below-range, above-range and NaN entries, placed right
// after the effective color count) as they pass the table stage and
// give no pixel. The table is not cleared at reset; read only entries
// that were written. Configuration must be written over APB only while
// the block is idle; the block itself does not enforce this.
`default_nettype none

module scalar_to_color_lut_mapper #(
  parameter int TABLE_DEPTH = 256
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // sample_value[31:0], entry_index[40:32], entry_color[72:41], zero pad
  input  wire logic [79:0]  s_axis_tdata_i,
  // command[0], sample_is_nan[1]
  input  wire logic [1:0]   s_axis_tuser_i,
  input  wire logic         s_axis_tlast_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // byte0[7:0], byte1[15:8], byte2[23:16], byte3[31:24], byte_count[34:32], zero pad
  output logic      [39:0]  m_axis_tdata_o,
  output logic              m_axis_tlast_o,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic      [31:0]  prdata,
  output logic              pready
);

  localparam int SlotW = $clog2(TABLE_DEPTH + 3);

  sclm_pkg::cfg_t     cfg;
  sclm_pkg::item_t    item;
  sclm_pkg::lookup_t  lookup;
  sclm_pkg::pixel_t   pixel;
  logic [SlotW-1:0]   slot;
  logic               lookup_valid, lookup_ready;

  assign item.command = sclm_pkg::command_e'(s_axis_tuser_i[0]);
  assign item.is_nan  = s_axis_tuser_i[1];
  assign item.last    = s_axis_tlast_i;
  assign item.entry   = s_axis_tdata_i[40:32];
  assign item.color   = s_axis_tdata_i[72:41];

  sclm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sclm_index #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_index (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_item_i    (item),
    .in_sample_i  (signed'(s_axis_tdata_i[31:0])),
    .out_valid_o  (lookup_valid),
    .out_ready_i  (lookup_ready),
    .out_lookup_o (lookup),
    .out_slot_o   (slot)
  );

  sclm_color #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_color (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (lookup_valid),
    .in_ready_o  (lookup_ready),
    .in_lookup_i (lookup),
    .in_slot_i   (slot),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_pixel_o (pixel)
  );

  assign m_axis_tdata_o = {5'd0, pixel.count, pixel.byte3, pixel.byte2, pixel.byte1,
                           pixel.byte0};
  assign m_axis_tlast_o = pixel.last;

endmodule

`default_nettype wire

>>> rtl/sclm_regs.sv
// APB configuration register file of the lookup mapper.
`default_nettype none

module sclm_regs (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  output sclm_pkg::cfg_t          cfg_o
);

  sclm_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;

  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (sclm_pkg::reg_addr_e'(paddr[4:2]))
        sclm_pkg::REG_RANGE_LOW:     cfg_d.range_low     = signed'(pwdata);
        sclm_pkg::REG_RANGE_HIGH:    cfg_d.range_high    = signed'(pwdata);
        sclm_pkg::REG_INDEX_SCALE:   cfg_d.index_scale   = pwdata;
        sclm_pkg::REG_ALPHA_FACTOR:  cfg_d.alpha_factor  = pwdata[8:0];
        sclm_pkg::REG_OUTPUT_FORMAT: cfg_d.output_format = sclm_pkg::format_e'(pwdata[1:0]);
        sclm_pkg::REG_COLOR_COUNT:   cfg_d.color_count   = pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.range_low     <= sclm_pkg::RST_RANGE_LOW;
      cfg_q.range_high    <= sclm_pkg::RST_RANGE_HIGH;
      cfg_q.index_scale   <= sclm_pkg::RST_INDEX_SCALE;
      cfg_q.alpha_factor  <= sclm_pkg::RST_ALPHA_FACTOR;
      cfg_q.output_format <= sclm_pkg::FMT_RGBA;
      cfg_q.color_count   <= sclm_pkg::RST_COLOR_COUNT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    prdata = '0;
    case (sclm_pkg::reg_addr_e'(paddr[4:2]))
      sclm_pkg::REG_RANGE_LOW:     prdata = cfg_q.range_low;
      sclm_pkg::REG_RANGE_HIGH:    prdata = cfg_q.range_high;
      sclm_pkg::REG_INDEX_SCALE:   prdata = cfg_q.index_scale;
      sclm_pkg::REG_ALPHA_FACTOR:  prdata = {23'd0, cfg_q.alpha_factor};
      sclm_pkg::REG_OUTPUT_FORMAT: prdata = {30'd0, cfg_q.output_format};
      sclm_pkg::REG_COLOR_COUNT:   prdata = {23'd0, cfg_q.color_count};
      default:                     prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/sclm_index.sv
// Index pipeline: range check, scale multiply and table slot selection.
`default_nettype none

module sclm_index #(
  parameter int TABLE_DEPTH = 256,
  localparam int SlotW = $clog2(TABLE_DEPTH + 3)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire sclm_pkg::cfg_t      cfg_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire sclm_pkg::item_t     in_item_i,
  input  wire logic signed [31:0]  in_sample_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output sclm_pkg::lookup_t        out_lookup_o,
  output logic [SlotW-1:0]         out_slot_o
);

  localparam int CntW = $clog2(TABLE_DEPTH + 1);
  localparam int CmpW = ((SlotW > 9) ? SlotW : 9) + 1;

  typedef enum logic [1:0] {
    KIND_COLOR = 2'd0,
    KIND_BELOW = 2'd1,
    KIND_ABOVE = 2'd2,
    KIND_NAN   = 2'd3
  } kind_e;

  // stage A: input capture
  logic                   a_valid_q;
  sclm_pkg::item_t        a_item_q;
  logic signed [31:0]     a_sample_q;
  // stage B: range classification and offset
  logic                   b_valid_q;
  sclm_pkg::item_t        b_item_q;
  kind_e                  b_kind_q, b_kind_d;
  logic [31:0]            b_diff_q, b_diff_d;
  // stage C: scaled index
  logic                   c_valid_q;
  sclm_pkg::item_t        c_item_q;
  kind_e                  c_kind_q;
  logic [31:0]            c_idx_q, c_idx_d;
  logic [63:0]            c_prod;
  // stage D: slot
  logic                   d_valid_q;
  sclm_pkg::lookup_t      d_lookup_q, d_lookup_d;
  logic [SlotW-1:0]       d_slot_q, d_slot_d;

  logic a_ready, b_ready, c_ready, d_ready;

  logic [CmpW-1:0]  count_ext;
  logic [CntW-1:0]  eff_count;
  logic [CntW-1:0]  last_color;

  assign d_ready    = !d_valid_q || out_ready_i;
  assign c_ready    = !c_valid_q || d_ready;
  assign b_ready    = !b_valid_q || c_ready;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  always_comb begin
    if (a_item_q.is_nan) begin
      b_kind_d = KIND_NAN;
    end else if (a_sample_q < cfg_i.range_low) begin
      b_kind_d = KIND_BELOW;
    end else if (a_sample_q > cfg_i.range_high) begin
      b_kind_d = KIND_ABOVE;
    end else begin
      b_kind_d = KIND_COLOR;
    end
    b_diff_d = 32'(a_sample_q - cfg_i.range_low);
  end

  assign c_prod  = 64'(b_diff_q) * 64'(cfg_i.index_scale);
  assign c_idx_d = c_prod[63:32];

  always_comb begin
    count_ext = CmpW'(cfg_i.color_count);
    if (cfg_i.color_count == 9'd0) begin
      eff_count = CntW'(1);
    end else if (count_ext > CmpW'(TABLE_DEPTH)) begin
      eff_count = CntW'(TABLE_DEPTH);
    end else begin
      eff_count = CntW'(count_ext);
    end
    last_color = eff_count - CntW'(1);
  end

  always_comb begin
    d_lookup_d.command = c_item_q.command;
    d_lookup_d.last    = c_item_q.last;
    d_lookup_d.color   = c_item_q.color;
    d_lookup_d.wr_ok   = CmpW'(c_item_q.entry) < CmpW'(TABLE_DEPTH + 3);
    if (c_item_q.command == sclm_pkg::CMD_WRITE) begin
      d_slot_d = SlotW'(c_item_q.entry);
    end else begin
      case (c_kind_q)
        KIND_NAN:   d_slot_d = SlotW'(eff_count) + SlotW'(2);
        KIND_BELOW: d_slot_d = SlotW'(eff_count);
        KIND_ABOVE: d_slot_d = SlotW'(eff_count) + SlotW'(1);
        default: begin
          if (c_idx_q > 32'(last_color)) begin
            d_slot_d = SlotW'(last_color);
          end else begin
            d_slot_d = SlotW'(c_idx_q);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= in_valid_i;
      if (b_ready) b_valid_q <= a_valid_q;
      if (c_ready) c_valid_q <= b_valid_q;
      if (d_ready) d_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      a_item_q   <= in_item_i;
      a_sample_q <= in_sample_i;
    end
    if (b_ready && a_valid_q) begin
      b_item_q <= a_item_q;
      b_kind_q <= b_kind_d;
      b_diff_q <= b_diff_d;
    end
    if (c_ready && b_valid_q) begin
      c_item_q <= b_item_q;
      c_kind_q <= b_kind_q;
      c_idx_q  <= c_idx_d;
    end
    if (d_ready && c_valid_q) begin
      d_lookup_q <= d_lookup_d;
      d_slot_q   <= d_slot_d;
    end
  end

  assign out_valid_o  = d_valid_q;
  assign out_lookup_o = d_lookup_q;
  assign out_slot_o   = d_slot_q;

endmodule

`default_nettype wire

>>> rtl/sclm_color.sv
// Color table memory, registered read and output formatting stage.
`default_nettype none

module sclm_color #(
  parameter int TABLE_DEPTH = 256,
  localparam int SlotW = $clog2(TABLE_DEPTH + 3)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire sclm_pkg::cfg_t     cfg_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire sclm_pkg::lookup_t  in_lookup_i,
  input  wire logic [SlotW-1:0]   in_slot_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output sclm_pkg::pixel_t        out_pixel_o
);

  localparam int Depth = TABLE_DEPTH + 3;

  logic [31:0] mem [Depth];

  logic              e_valid_q;
  logic              e_last_q;
  logic [31:0]       e_word_q;
  logic              f_valid_q;
  sclm_pkg::pixel_t  f_pixel_q, f_pixel_d;
  logic              e_ready, f_ready;
  logic              take;

  logic [7:0]  red, green, blue, alpha;
  logic [8:0]  factor;
  logic [15:0] alpha_sum, lum_sum;
  logic [7:0]  alpha_scaled, lum;

  assign f_ready    = !f_valid_q || out_ready_i;
  assign e_ready    = !e_valid_q || f_ready;
  assign in_ready_o = e_ready;
  assign take       = in_valid_i && e_ready;

  always_ff @(posedge clk_i) begin
    if (take) begin
      if (in_lookup_i.command == sclm_pkg::CMD_WRITE) begin
        if (in_lookup_i.wr_ok) mem[in_slot_i] <= in_lookup_i.color;
      end else begin
        e_word_q <= mem[in_slot_i];
      end
      e_last_q <= in_lookup_i.last;
    end
  end

  always_comb begin
    red    = e_word_q[7:0];
    green  = e_word_q[15:8];
    blue   = e_word_q[23:16];
    alpha  = e_word_q[31:24];
    factor = (cfg_i.alpha_factor > sclm_pkg::ALPHA_UNITY) ? sclm_pkg::ALPHA_UNITY
                                                          : cfg_i.alpha_factor;
    alpha_sum = 16'(17'(alpha) * 17'(factor)) + sclm_pkg::ROUND_HALF;
    lum_sum   = 16'(red) * sclm_pkg::LUM_R_COEF + 16'(green) * sclm_pkg::LUM_G_COEF
              + 16'(blue) * sclm_pkg::LUM_B_COEF + sclm_pkg::ROUND_HALF;
    alpha_scaled = alpha_sum[15:8];
    lum          = lum_sum[15:8];

    f_pixel_d      = '0;
    f_pixel_d.last = e_last_q;
    case (cfg_i.output_format)
      sclm_pkg::FMT_RGBA: begin
        f_pixel_d.byte0 = red;
        f_pixel_d.byte1 = green;
        f_pixel_d.byte2 = blue;
        f_pixel_d.byte3 = alpha_scaled;
        f_pixel_d.count = sclm_pkg::COUNT_RGBA;
      end
      sclm_pkg::FMT_RGB: begin
        f_pixel_d.byte0 = red;
        f_pixel_d.byte1 = green;
        f_pixel_d.byte2 = blue;
        f_pixel_d.count = sclm_pkg::COUNT_RGB;
      end
      sclm_pkg::FMT_LUM_ALPHA: begin
        f_pixel_d.byte0 = lum;
        f_pixel_d.byte1 = alpha_scaled;
        f_pixel_d.count = sclm_pkg::COUNT_LUM_ALPHA;
      end
      default: begin
        f_pixel_d.byte0 = lum;
        f_pixel_d.count = sclm_pkg::COUNT_LUM;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
      f_valid_q <= 1'b0;
    end else begin
      if (e_ready) e_valid_q <= in_valid_i && (in_lookup_i.command == sclm_pkg::CMD_MAP);
      if (f_ready) f_valid_q <= e_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (f_ready && e_valid_q) f_pixel_q <= f_pixel_d;
  end

  assign out_valid_o = f_valid_q;
  assign out_pixel_o = f_pixel_q;

endmodule

`default_nettype wire

>>> rtl/sclm_checker.sv
// Port-level checker of the lookup mapper and its bind to the top level.
`default_nettype none

module sclm_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tready_o,
  input wire logic         m_axis_tvalid_o,
  input wire logic         m_axis_tready_i,
  input wire logic [39:0]  m_axis_tdata_o,
  input wire logic         m_axis_tlast_o,
  input wire logic         psel,
  input wire logic         penable,
  input wire logic         pwrite,
  input wire logic [4:0]   paddr,
  input wire logic [31:0]  pwdata,
  input wire logic [31:0]  prdata,
  input wire logic         pready
);

  assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid_o)
    else $error("output valid during reset");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("stalled output transaction dropped");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled output transaction changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(psel && penable && pwrite && pready && paddr[4:2] == sclm_pkg::REG_OUTPUT_FORMAT)
    && psel && !pwrite && paddr[4:2] == sclm_pkg::REG_OUTPUT_FORMAT
    |-> prdata[1:0] == $past(pwdata[1:0]))
    else $error("output format readback mismatch");

endmodule

bind scalar_to_color_lut_mapper sclm_checker u_checker (.*);

`default_nettype wire
